// ===== src/tgs_pkg.sv =====
// ----------------------------------------------------------------------------
// tgs_pkg: shared types and constants for the terrain gravity step block
// Grid size, height bank layout, config register codes and pipeline structs.
// ----------------------------------------------------------------------------
package tgs_pkg;

	// Terrain grid is GRID_POINTS x GRID_POINTS height samples
	localparam int GRID_POINTS = 256;
	localparam int GRID_BITS   = (GRID_POINTS <= 2) ? 1 : $clog2(GRID_POINTS);
	localparam int HALF_W      = GRID_BITS - 1;
	// Table is split in four banks by the parity of column and row
	localparam int NUM_BANKS   = 4;
	localparam int ADDR_W      = (HALF_W == 0) ? 1 : 2 * HALF_W;
	localparam int BANK_DEPTH  = 1 << ADDR_W;

	// Stream word widths
	localparam int IN_W  = 264;
	localparam int OUT_W = 168;

	// Fixed-point constants
	localparam logic [16:0] ONE_Q16       = 17'h10000;
	localparam logic [31:0] GRAVITY_RESET = 32'hFFCF_0000;
	localparam logic [30:0] CPU_RESET     = 31'h0001_0000;

	// Config register indexes
	typedef enum logic [1:0] {
		CFG_GRAVITY,
		CFG_ORIGIN_X,
		CFG_ORIGIN_Z,
		CFG_CELLS_PER_UNIT
	} cfg_idx_t;

	// Input word kinds
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// Body state carried down the pipeline
	typedef struct packed {
		logic        grav_on;
		logic        clip;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [31:0] vy;
	} body_t;

	// Height table write carried down the pipeline
	typedef struct packed {
		logic [GRID_BITS-1:0] x;
		logic [GRID_BITS-1:0] z;
		logic [31:0]          data;
	} wr_t;

	// Address of a grid point inside its parity bank
	function automatic logic [ADDR_W-1:0] bank_addr(input logic [GRID_BITS-1:0] x,
			input logic [GRID_BITS-1:0] z);
		logic [2*GRID_BITS-1:0] a;
		a = ((2*GRID_BITS)'(z >> 1) << HALF_W) | (2*GRID_BITS)'(x >> 1);
		return a[ADDR_W-1:0];
	endfunction

endpackage

// ===== src/terrain_gravity_step.sv =====
// ----------------------------------------------------------------------------
// terrain_gravity_step: Euler step of bodies over a height-field terrain
// Input stream carries table writes (s_tuser low) and body steps (s_tuser
// high). Each step word yields one result word on the master side; a write
// word stores one height sample and yields nothing.
// Config port: cfg_we, cfg_addr and cfg_wdata write gravity, grid origin x,
// grid origin z and cells per unit; write only while the block is idle.
// Pipeline: a step word passes stages 1 to 6 and then the output register,
// all loaded together whenever the pipeline moves. Throughput is one word
// per cycle while the receiver does not stall; the four corner heights come
// from four parity banks read in the same cycle, and table writes land in
// the read stage so order is kept.
// Reset clears all valid bits and loads the config reset values; the height
// table holds garbage until written. When the receiver stalls, the whole
// pipeline freezes and s_tready drops in the same cycle; nothing is lost.
// ----------------------------------------------------------------------------
module terrain_gravity_step (
	input  logic                     clk,
	input  logic                     arst_n,
	// tdata: cell_x, cell_z, height_value, pos_x, pos_y, pos_z, vel_x, vel_y,
	// vel_z, gravity_on, time_step, zero pad
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [tgs_pkg::IN_W-1:0] s_tdata,
	// tuser: action
	input  logic                     s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// tdata: new_pos_x, new_pos_y, new_pos_z, new_vel_y, terrain_height,
	// landed, off_map, saturated, zero pad
	output logic [tgs_pkg::OUT_W-1:0] m_tdata,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_addr,
	input  logic [31:0]              cfg_wdata
);

	logic [31:0]          gravity_q, origin_x_q, origin_z_q;
	logic [30:0]          cpu_q;
	logic                 en, acc, wr_ok, in_step, in_wr;
	tgs_pkg::wr_t         in_wrd, wrd_s3;
	logic                 step_s3, wen_s3, step_s6, off_s6;
	tgs_pkg::body_t       body_s3, body_s6;
	logic signed [63:0]   cx_s3, cz_s3;
	logic [31:0]          height_s6;
	logic                 land;
	logic                 out_valid_q, landed_q, off_q, sat_q;
	logic [31:0]          px_q, py_q, pz_q, vy_q, h_q;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q  <= tgs_pkg::GRAVITY_RESET;
			origin_x_q <= '0;
			origin_z_q <= '0;
			cpu_q      <= tgs_pkg::CPU_RESET;
		end else if (cfg_we) begin
			unique case (tgs_pkg::cfg_idx_t'(cfg_addr))
				tgs_pkg::CFG_GRAVITY:        gravity_q  <= cfg_wdata;
				tgs_pkg::CFG_ORIGIN_X:       origin_x_q <= cfg_wdata;
				tgs_pkg::CFG_ORIGIN_Z:       origin_z_q <= cfg_wdata;
				tgs_pkg::CFG_CELLS_PER_UNIT: cpu_q      <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// Pipeline moves whenever the output register can take a word
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign acc      = s_tvalid & s_tready;

	// Drop writes outside the grid
	assign wr_ok   = (32'(s_tdata[7:0]) < 32'(tgs_pkg::GRID_POINTS))
		&& (32'(s_tdata[15:8]) < 32'(tgs_pkg::GRID_POINTS));
	assign in_step = acc & (s_tuser == tgs_pkg::ACT_STEP);
	assign in_wr   = acc & (s_tuser == tgs_pkg::ACT_WRITE) & wr_ok;

	assign in_wrd.x    = tgs_pkg::GRID_BITS'(s_tdata[7:0]);
	assign in_wrd.z    = tgs_pkg::GRID_BITS'(s_tdata[15:8]);
	assign in_wrd.data = s_tdata[47:16];

	tgs_kin u_kin (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_step         (in_step),
		.in_wr           (in_wr),
		.pos_x           (s_tdata[79:48]),
		.pos_y           (s_tdata[111:80]),
		.pos_z           (s_tdata[143:112]),
		.vel_x           (s_tdata[175:144]),
		.vel_y           (s_tdata[207:176]),
		.vel_z           (s_tdata[239:208]),
		.gravity_on      (s_tdata[240]),
		.time_step       (s_tdata[260:241]),
		.in_wrd          (in_wrd),
		.gravity         (gravity_q),
		.ground_origin_x (origin_x_q),
		.ground_origin_z (origin_z_q),
		.cells_per_unit  (cpu_q),
		.step_s3         (step_s3),
		.wen_s3          (wen_s3),
		.body_s3         (body_s3),
		.wrd_s3          (wrd_s3),
		.cx_s3           (cx_s3),
		.cz_s3           (cz_s3)
	);

	tgs_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.step_in   (step_s3),
		.wen_in    (wen_s3),
		.body_in   (body_s3),
		.wrd_in    (wrd_s3),
		.cx_in     (cx_s3),
		.cz_in     (cz_s3),
		.step_s6   (step_s6),
		.body_s6   (body_s6),
		.height_s6 (height_s6),
		.off_s6    (off_s6)
	);

	// Land the body when gravity is on and it sinks below the terrain
	assign land = body_s6.grav_on && ($signed(body_s6.py) < $signed(height_s6));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= step_s6;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			px_q     <= body_s6.px;
			py_q     <= land ? height_s6 : body_s6.py;
			pz_q     <= body_s6.pz;
			vy_q     <= land ? 32'h0 : body_s6.vy;
			h_q      <= height_s6;
			landed_q <= land;
			off_q    <= off_s6;
			sat_q    <= body_s6.clip;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, sat_q, off_q, landed_q, h_q, vy_q, pz_q, py_q, px_q};

	// Checks
	a_land_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && landed_q |-> vy_q == 32'h0)
		else $error("landed body keeps vertical velocity");

	a_land_on_ground: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && landed_q |-> py_q == h_q)
		else $error("landed body not on terrain");

	a_off_flat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && off_q |-> h_q == 32'h0)
		else $error("off-map height not zero");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

endmodule

// ===== src/tgs_ram.sv =====
// ----------------------------------------------------------------------------
// tgs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module tgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read, read data held when not enabled
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/tgs_kin.sv =====
// ----------------------------------------------------------------------------
// tgs_kin: kinematic stages of the step pipeline
// Stage 1 multiplies rates by the time step, stage 2 rounds, adds and
// saturates, stage 3 maps the new x and z to Q32 grid coordinates.
// ----------------------------------------------------------------------------
module tgs_kin (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_step,
	input  logic                in_wr,
	input  logic [31:0]         pos_x,
	input  logic [31:0]         pos_y,
	input  logic [31:0]         pos_z,
	input  logic [31:0]         vel_x,
	input  logic [31:0]         vel_y,
	input  logic [31:0]         vel_z,
	input  logic                gravity_on,
	input  logic [19:0]         time_step,
	input  tgs_pkg::wr_t        in_wrd,
	input  logic [31:0]         gravity,
	input  logic [31:0]         ground_origin_x,
	input  logic [31:0]         ground_origin_z,
	input  logic [30:0]         cells_per_unit,
	output logic                step_s3,
	output logic                wen_s3,
	output tgs_pkg::body_t      body_s3,
	output tgs_pkg::wr_t        wrd_s3,
	output logic signed [63:0]  cx_s3,
	output logic signed [63:0]  cz_s3
);

	logic                step_s1, wen_s1, step_s2, wen_s2;
	logic signed [52:0]  mx_s1, my_s1, mz_s1, mg_s1;
	logic [31:0]         px_s1, py_s1, pz_s1, vy_s1;
	logic                gon_s1;
	tgs_pkg::wr_t        wrd_s1, wrd_s2;
	tgs_pkg::body_t      body_s2;
	logic signed [20:0]  dt;
	logic [32:0]         ax, ay, az, ag;
	logic signed [32:0]  dx, dz;

	// Round a Q15.16 x Q4.16 product to Q15.16, add, saturate; {clip, value}
	function automatic logic [32:0] adv(input logic [31:0] base,
			input logic signed [52:0] m);
		logic signed [36:0] d;
		logic signed [37:0] s;
		d = 37'((m + 53'sd32768) >>> 16);
		s = 38'($signed(base)) + 38'(d);
		if (s > 38'sd2147483647) begin
			return {1'b1, 32'h7FFF_FFFF};
		end else if (s < -38'sd2147483648) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, s[31:0]};
	endfunction

	assign dt = $signed({1'b0, time_step});

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= 1'b0;
			wen_s1  <= 1'b0;
			step_s2 <= 1'b0;
			wen_s2  <= 1'b0;
			step_s3 <= 1'b0;
			wen_s3  <= 1'b0;
		end else if (en) begin
			step_s1 <= in_step;
			wen_s1  <= in_wr;
			step_s2 <= step_s1;
			wen_s2  <= wen_s1;
			step_s3 <= step_s2;
			wen_s3  <= wen_s2;
		end
	end

	// Stage 1: rate times time step
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1  <= $signed(vel_x) * dt;
			my_s1  <= $signed(vel_y) * dt;
			mz_s1  <= $signed(vel_z) * dt;
			mg_s1  <= $signed(gravity) * dt;
			px_s1  <= pos_x;
			py_s1  <= pos_y;
			pz_s1  <= pos_z;
			vy_s1  <= vel_y;
			gon_s1 <= gravity_on;
			wrd_s1 <= in_wrd;
		end
	end

	// Stage 2: round, add and saturate
	assign ax = adv(px_s1, mx_s1);
	assign ay = adv(py_s1, my_s1);
	assign az = adv(pz_s1, mz_s1);
	assign ag = adv(vy_s1, mg_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			body_s2.grav_on <= gon_s1;
			body_s2.clip    <= ax[32] | ay[32] | az[32] | (gon_s1 & ag[32]);
			body_s2.px      <= ax[31:0];
			body_s2.py      <= ay[31:0];
			body_s2.pz      <= az[31:0];
			body_s2.vy      <= gon_s1 ? ag[31:0] : vy_s1;
			wrd_s2          <= wrd_s1;
		end
	end

	// Stage 3: grid coordinate in Q32
	assign dx = $signed({body_s2.px[31], body_s2.px})
		- $signed({ground_origin_x[31], ground_origin_x});
	assign dz = $signed({body_s2.pz[31], body_s2.pz})
		- $signed({ground_origin_z[31], ground_origin_z});

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s3   <= dx * $signed({1'b0, cells_per_unit});
			cz_s3   <= dz * $signed({1'b0, cells_per_unit});
			body_s3 <= body_s2;
			wrd_s3  <= wrd_s2;
		end
	end

endmodule

// ===== src/tgs_interp.sv =====
// ----------------------------------------------------------------------------
// tgs_interp: terrain lookup and barycentric interpolation stages
// Stage 4 reads the four corner banks and picks triangle weights, stage 5
// weighs each corner, stage 6 sums and rounds. Table writes land in stage 4.
// ----------------------------------------------------------------------------
module tgs_interp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     step_in,
	input  logic                     wen_in,
	input  tgs_pkg::body_t           body_in,
	input  tgs_pkg::wr_t             wrd_in,
	input  logic signed [63:0]       cx_in,
	input  logic signed [63:0]       cz_in,
	output logic                     step_s6,
	output tgs_pkg::body_t           body_s6,
	output logic [31:0]              height_s6,
	output logic                     off_s6
);

	logic [31:0]                  gx, gz;
	logic [15:0]                  fx, fz;
	logic [16:0]                  fsum;
	logic                         upper, off;
	logic [tgs_pkg::GRID_BITS-1:0] xs, xs1, zs, zs1;
	logic [16:0]                  w00, w10, w01, w11;
	logic [tgs_pkg::ADDR_W-1:0]   waddr;
	logic [1:0]                   wbank;

	logic [tgs_pkg::ADDR_W-1:0]   raddr [tgs_pkg::NUM_BANKS];
	logic [16:0]                  wsel  [tgs_pkg::NUM_BANKS];
	logic [31:0]                  rdata [tgs_pkg::NUM_BANKS];
	logic [16:0]                  w_s4  [tgs_pkg::NUM_BANKS];
	logic signed [49:0]           p_s5  [tgs_pkg::NUM_BANKS];

	logic                         step_s4, step_s5, off_s4, off_s5;
	tgs_pkg::body_t               body_s4, body_s5;
	logic signed [51:0]           sum;

	// Split grid coordinates into cell and in-cell fraction
	assign gx    = cx_in[63:32];
	assign gz    = cz_in[63:32];
	assign fx    = cx_in[31:16];
	assign fz    = cz_in[31:16];
	assign fsum  = {1'b0, fx} + {1'b0, fz};
	assign upper = fsum > tgs_pkg::ONE_Q16;
	assign off   = gx[31] | gz[31] | (gx >= 32'(tgs_pkg::GRID_POINTS - 1))
		| (gz >= 32'(tgs_pkg::GRID_POINTS - 1));
	assign xs    = gx[tgs_pkg::GRID_BITS-1:0];
	assign zs    = gz[tgs_pkg::GRID_BITS-1:0];
	assign xs1   = xs + 1'b1;
	assign zs1   = zs + 1'b1;

	// Corner weights of the selected triangle
	always_comb begin
		if (upper) begin
			w00 = '0;
			w10 = tgs_pkg::ONE_Q16 - {1'b0, fz};
			w11 = fsum - tgs_pkg::ONE_Q16;
			w01 = tgs_pkg::ONE_Q16 - {1'b0, fx};
		end else begin
			w00 = tgs_pkg::ONE_Q16 - fsum;
			w10 = {1'b0, fx};
			w01 = {1'b0, fz};
			w11 = '0;
		end
	end

	assign waddr = tgs_pkg::bank_addr(wrd_in.x, wrd_in.z);
	assign wbank = {wrd_in.z[0], wrd_in.x[0]};

	// One bank per column and row parity; each corner hits its own bank
	for (genvar b = 0; b < tgs_pkg::NUM_BANKS; b++) begin : g_bank
		localparam logic [1:0] BID = 2'(b);
		logic cdx, cdz;

		assign cdx      = BID[0] ^ xs[0];
		assign cdz      = BID[1] ^ zs[0];
		assign raddr[b] = tgs_pkg::bank_addr(cdx ? xs1 : xs, cdz ? zs1 : zs);

		always_comb begin
			case ({cdz, cdx})
				2'b00:   wsel[b] = w00;
				2'b01:   wsel[b] = w10;
				2'b10:   wsel[b] = w01;
				default: wsel[b] = w11;
			endcase
		end

		tgs_ram #(
			.WIDTH(32),
			.DEPTH(tgs_pkg::BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (en & wen_in & (wbank == BID)),
			.waddr (waddr),
			.wdata (wrd_in.data),
			.re    (en),
			.raddr (raddr[b]),
			.rdata (rdata[b])
		);

		// Stage 4 weight, stage 5 weighted corner
		always_ff @(posedge clk) begin
			if (en) begin
				w_s4[b] <= wsel[b];
				p_s5[b] <= $signed(rdata[b]) * $signed({1'b0, w_s4[b]});
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s4 <= 1'b0;
			step_s5 <= 1'b0;
			step_s6 <= 1'b0;
		end else if (en) begin
			step_s4 <= step_in;
			step_s5 <= step_s4;
			step_s6 <= step_s5;
		end
	end

	// Stage 6: sum corners, round to nearest
	assign sum = 52'(p_s5[0]) + 52'(p_s5[1]) + 52'(p_s5[2]) + 52'(p_s5[3])
		+ 52'sd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			body_s4   <= body_in;
			off_s4    <= off;
			body_s5   <= body_s4;
			off_s5    <= off_s4;
			body_s6   <= body_s5;
			off_s6    <= off_s5;
			height_s6 <= off_s5 ? 32'h0 : sum[47:16];
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for terrain_gravity_step
// Loads a block of the height grid, then runs a stimulus table followed by
// random table writes and body steps under several config settings. Every
// result word is compared with a known answer or a behavioral predictor,
// while both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int  GP        = tgs_pkg::GRID_POINTS;
	localparam int  LOAD_SPAN = 16;
	localparam int  PHASE_LEN = 163;
	localparam int  LIMIT     = 1000000;
	localparam real HALF_CLK  = 10.0;

	// One input word, unpacked
	typedef struct {
		logic        act;
		logic [7:0]  cx;
		logic [7:0]  cz;
		logic [31:0] hv;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic        gon;
		logic [19:0] dt;
	} body_in_t;

	// One result word
	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [31:0] vy;
		logic [31:0] h;
		logic        landed;
		logic        off;
		logic        sat;
	} body_out_t;

	typedef struct {
		body_in_t  it;
		bit        known;
		body_out_t res;
	} stim_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [tgs_pkg::IN_W-1:0]   s_tdata = '0;
	logic                       s_tuser = 1'b0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [tgs_pkg::OUT_W-1:0]  m_tdata;
	logic                       cfg_we = 1'b0;
	logic [1:0]                 cfg_addr = '0;
	logic [31:0]                cfg_wdata = '0;

	// Predictor state
	logic [31:0] heights[GP*GP];
	bit          written[GP*GP];
	longint      grav, org_x, org_z, cpu;
	body_out_t   pending[$];

	int          errors = 0;
	int          cycles = 0;
	int          n_steps = 0, n_writes = 0, n_landed = 0, n_off = 0, n_sat = 0;
	int          stall_left = 0;
	bit          quiet = 0;
	stim_row_t   rows[$];

	terrain_gravity_step uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #(HALF_CLK) clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending.size());
			$display("simulation failed");
			$finish;
		end
	end

	function automatic longint clip32(longint v, inout bit c);
		if (v > 64'sd2147483647) begin
			c = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			c = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Add rate * dt, rounded to nearest, ties up, then saturate
	function automatic longint euler(longint base, longint rate, longint dt, inout bit c);
		longint d;
		d = (rate * dt + 32768) >>> 16;
		return clip32(base + d, c);
	endfunction

	function automatic longint sx(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint hget(longint x, longint z);
		return sx(heights[z * GP + x]);
	endfunction

	// Barycentric ground height under (px, pz); zero off the grid
	function automatic longint ground(longint px, longint pz, output bit off);
		longint cxl, czl, gx, gz, fx, fz, sum;
		cxl = (px - org_x) * cpu;
		czl = (pz - org_z) * cpu;
		fx = (cxl >>> 16) & 64'hFFFF;
		fz = (czl >>> 16) & 64'hFFFF;
		gx = cxl >>> 32;
		gz = czl >>> 32;
		off = (gx < 0 || gz < 0 || gx >= GP - 1 || gz >= GP - 1);
		if (off)
			return 0;
		if (fx + fz <= 65536)
			sum = hget(gx, gz) * (65536 - fx - fz) + hget(gx + 1, gz) * fx
				+ hget(gx, gz + 1) * fz;
		else
			sum = hget(gx + 1, gz) * (65536 - fz) + hget(gx + 1, gz + 1) * (fx + fz - 65536)
				+ hget(gx, gz + 1) * (65536 - fx);
		return (sum + 32768) >>> 16;
	endfunction

	// True if the step only touches loaded corners of its cell
	function automatic bit reads_ok(body_in_t it);
		longint dt, px, pz, cxl, czl, gx, gz;
		bit     c;
		if (it.act == tgs_pkg::ACT_WRITE)
			return 1;
		c = 0;
		dt = longint'(it.dt);
		px = euler(sx(it.px), sx(it.vx), dt, c);
		pz = euler(sx(it.pz), sx(it.vz), dt, c);
		cxl = (px - org_x) * cpu;
		czl = (pz - org_z) * cpu;
		gx = cxl >>> 32;
		gz = czl >>> 32;
		if (gx < 0 || gz < 0 || gx >= GP - 1 || gz >= GP - 1)
			return 1;
		return written[gz * GP + gx] && written[gz * GP + gx + 1]
			&& written[(gz + 1) * GP + gx] && written[(gz + 1) * GP + gx + 1];
	endfunction

	function automatic body_out_t step_body(body_in_t it);
		body_out_t r;
		bit        c, off;
		longint    dt, px, py, pz, vy, h;
		c = 0;
		dt = longint'(it.dt);
		vy = sx(it.vy);
		px = euler(sx(it.px), sx(it.vx), dt, c);
		py = euler(sx(it.py), vy, dt, c);
		pz = euler(sx(it.pz), sx(it.vz), dt, c);
		h = ground(px, pz, off);
		r.landed = 0;
		if (it.gon) begin
			vy = euler(vy, grav, dt, c);
			if (py < h) begin
				py = h;
				vy = 0;
				r.landed = 1;
			end
		end
		r.px = px[31:0];
		r.py = py[31:0];
		r.pz = pz[31:0];
		r.vy = vy[31:0];
		r.h = h[31:0];
		r.off = off;
		r.sat = c;
		return r;
	endfunction

	function automatic logic [tgs_pkg::IN_W-1:0] pack_in(body_in_t it);
		return {3'b0, it.dt, it.gon, it.vz, it.vy, it.vx, it.pz, it.py, it.px, it.hv,
			it.cz, it.cx};
	endfunction

	// Short gaps mostly, a few long ones, none in quiet stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Offer one word and hold it until accepted, then update the predictor
	task automatic push_word(body_in_t it, bit known, body_out_t res, bit fast);
		int gap;
		gap = fast ? ($urandom_range(0, 15) == 0) : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_in(it);
		s_tuser <= it.act;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (it.act == tgs_pkg::ACT_WRITE) begin
			heights[it.cz * GP + it.cx] = it.hv;
			written[it.cz * GP + it.cx] = 1;
			n_writes++;
		end else begin
			pending.push_back(known ? res : step_body(it));
			n_steps++;
		end
	endtask

	// Drop valid, drain every result, let the last write settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Write one register; the caller drops cfg_we after the last write
	task automatic cfg_write(tgs_pkg::cfg_idx_t idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			tgs_pkg::CFG_GRAVITY:        grav = sx(v);
			tgs_pkg::CFG_ORIGIN_X:       org_x = sx(v);
			tgs_pkg::CFG_ORIGIN_Z:       org_z = sx(v);
			tgs_pkg::CFG_CELLS_PER_UNIT: cpu = longint'(v[30:0]);
		endcase
	endtask

	// World coordinate for a cell position given in Q16 cells
	function automatic logic [31:0] place(longint org, longint c);
		longint p;
		bit     dummy;
		if (cpu == 0)
			return $urandom;
		dummy = 0;
		p = clip32(org + (c * 65536) / cpu, dummy);
		return p[31:0];
	endfunction

	function automatic logic [31:0] near(int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	function automatic body_in_t rand_item();
		body_in_t it;
		int       r;
		r = $urandom_range(0, 99);
		it.act = tgs_pkg::ACT_STEP;
		it.cx = 8'($urandom);
		it.cz = 8'($urandom);
		it.hv = ($urandom_range(0, 19) == 0) ? $urandom : near(32 << 16);
		it.px = $urandom;
		it.py = $urandom;
		it.pz = $urandom;
		it.vx = $urandom;
		it.vy = $urandom;
		it.vz = $urandom;
		it.gon = 1'($urandom);
		it.dt = 20'($urandom);
		if (r < 15) begin
			it.act = tgs_pkg::ACT_WRITE;
			// mostly rewrite the loaded block
			if ($urandom_range(0, 7) != 0) begin
				it.cx = 8'($urandom_range(0, LOAD_SPAN - 1));
				it.cz = 8'($urandom_range(0, LOAD_SPAN - 1));
			end
		end else if (r >= 27) begin
			// well-formed body over the loaded block with moderate motion
			it.px = place(org_x, $urandom_range(0, ((LOAD_SPAN - 1) << 16) - 1));
			it.pz = place(org_z, $urandom_range(0, ((LOAD_SPAN - 1) << 16) - 1));
			it.py = near(40 << 16);
			it.vx = near(8 << 16);
			it.vy = near(16 << 16);
			it.vz = near(8 << 16);
			it.gon = ($urandom_range(0, 4) != 0);
			it.dt = 20'($urandom_range(0, 20'h8000));
		end
		return it;
	endfunction

	// Draw until the word reads only loaded heights
	function automatic body_in_t next_item();
		body_in_t it;
		it = rand_item();
		while (!reads_ok(it))
			it = rand_item();
		return it;
	endfunction

	// Receiver: check each accepted word, then choose the next stall
	always @(posedge clk) begin
		body_out_t e, a;
		logic      rdy;
		if (arst_n && m_tvalid && m_tready) begin
			a.px = m_tdata[31:0];
			a.py = m_tdata[63:32];
			a.pz = m_tdata[95:64];
			a.vy = m_tdata[127:96];
			a.h = m_tdata[159:128];
			a.landed = m_tdata[160];
			a.off = m_tdata[161];
			a.sat = m_tdata[162];
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, m_tdata);
				errors++;
			end else begin
				e = pending.pop_front();
				if (e !== a) begin
					$display("%0t: mismatch expected pos %h %h %h vy %h h %h l%b o%b s%b",
						$time, e.px, e.py, e.pz, e.vy, e.h, e.landed, e.off, e.sat);
					$display("%0t:          actual   pos %h %h %h vy %h h %h l%b o%b s%b",
						$time, a.px, a.py, a.pz, a.vy, a.h, a.landed, a.off, a.sat);
					errors++;
				end
				n_landed += a.landed;
				n_off += a.off;
				n_sat += a.sat;
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			rdy = 1'b0;
		end else begin
			stall_left = quiet ? 0 : pick_gap();
			rdy = (stall_left == 0);
		end
		m_tready <= rdy;
	end

	function automatic body_in_t mk(logic act, logic [7:0] cx, logic [7:0] cz,
			logic [31:0] hv, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic gon, logic [19:0] dt);
		body_in_t it;
		it = '{act, cx, cz, hv, px, py, pz, vx, vy, vz, gon, dt};
		return it;
	endfunction

	function automatic body_out_t rs(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] vy, logic [31:0] h, logic l, logic o, logic s);
		body_out_t r;
		r = '{px, py, pz, vy, h, l, o, s};
		return r;
	endfunction

	task automatic add_row(body_in_t it, bit known, body_out_t res);
		stim_row_t row;
		row.it = it;
		row.known = known;
		row.res = res;
		rows.push_back(row);
	endtask

	// Setting per random phase: gravity, origin x, origin z, cells per unit
	logic [31:0] phase_cfg[6][4] = '{
		'{32'h0000_0000, 32'hFFF6_0000, 32'h0005_8000, 32'h0002_0000},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
		'{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
		'{32'hFFF6_3334, 32'h0003_4000, 32'hFFFE_0000, 32'h0000_8000},
		'{32'hFFCF_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000},
		'{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001}
	};

	initial begin
		body_out_t none;
		body_in_t  it;
		none = rs(0, 0, 0, 0, 0, 0, 0, 0);
		grav = sx(tgs_pkg::GRAVITY_RESET);
		org_x = 0;
		org_z = 0;
		cpu = longint'(tgs_pkg::CPU_RESET);

		// Stimulus table: known answers where obvious, predictor elsewhere
		add_row(mk(tgs_pkg::ACT_WRITE, 0, 0, 32'h0005_0000, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(mk(tgs_pkg::ACT_WRITE, 1, 0, 32'h0005_0000, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(mk(tgs_pkg::ACT_WRITE, 0, 1, 32'h0005_0000, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(mk(tgs_pkg::ACT_WRITE, 1, 1, 32'h0005_0000, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
		// land on a flat cell
		add_row(mk(tgs_pkg::ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1,
			rs(0, 32'h0005_0000, 0, 0, 32'h0005_0000, 1, 0, 0));
		// gravity off: stays below ground
		add_row(mk(tgs_pkg::ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			rs(0, 0, 0, 0, 32'h0005_0000, 0, 0, 0));
		// west of the grid
		add_row(mk(tgs_pkg::ACT_STEP, 0, 0, 0, 32'hFFFF_0000, 0, 0, 0, 0, 0, 1, 0), 1,
			rs(32'hFFFF_0000, 0, 0, 0, 0, 0, 1, 0));
		// positive and negative clipping
		add_row(mk(tgs_pkg::ACT_STEP, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0, 0,
			20'hFFFFF), 1, rs(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1, 1));
		add_row(mk(tgs_pkg::ACT_STEP, 0, 0, 0, 32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0, 0,
			20'hFFFFF), 1, rs(32'h8000_0000, 0, 0, 0, 0, 0, 1, 1));
		// extreme heights at the far corner
		add_row(mk(tgs_pkg::ACT_WRITE, 255, 255, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0),
			0, none);
		add_row(mk(tgs_pkg::ACT_WRITE, 254, 254, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0),
			0, none);
		add_row(mk(tgs_pkg::ACT_WRITE, 254, 255, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0),
			0, none);
		add_row(mk(tgs_pkg::ACT_WRITE, 255, 254, 32'h0000_0001, 0, 0, 0, 0, 0, 0, 0, 0),
			0, none);
		add_row(mk(tgs_pkg::ACT_STEP, 0, 0, 0, 32'h00FE_8000, 32'h8000_0000, 32'h00FE_8000, 0,
			32'h8000_0000, 0, 1, 20'hFFFFF), 0, none);
		add_row(mk(tgs_pkg::ACT_STEP, 0, 0, 0, 32'h00FE_4000, 32'h7FFF_FFFF, 32'h00FE_C000,
			32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 1, 20'h10000), 0, none);
		// last grid line is off the map
		add_row(mk(tgs_pkg::ACT_STEP, 0, 0, 0, 32'h00FF_0000, 0, 0, 0, 0, 0, 0, 0), 1,
			rs(32'h00FF_0000, 0, 0, 0, 0, 0, 1, 0));
		// upper triangle of a cell, then a moving body
		add_row(mk(tgs_pkg::ACT_STEP, 0, 0, 0, 32'h0000_C000, 0, 32'h0000_C000, 0, 0, 0, 1, 0),
			0, none);
		add_row(mk(tgs_pkg::ACT_STEP, 0, 0, 0, 32'h0000_4000, 32'h0006_0000, 32'h0000_8000,
			32'h0002_0000, 32'hFFFE_0000, 32'h0001_8000, 1, 20'h0800), 0, none);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load a block at the grid corner; bodies only read loaded heights
		for (int zi = 0; zi < LOAD_SPAN; zi++) begin
			for (int xi = 0; xi < LOAD_SPAN; xi++) begin
				it = mk(tgs_pkg::ACT_WRITE, 8'(xi), 8'(zi), near(32 << 16),
					0, 0, 0, 0, 0, 0, 0, 0);
				if ($urandom_range(0, 19) == 0)
					it.hv = $urandom;
				push_word(it, 0, none, 1);
			end
		end

		foreach (rows[i])
			push_word(rows[i].it, rows[i].known, rows[i].res, 0);

		for (int p = 0; p < 6; p++) begin
			drain();
			cfg_write(tgs_pkg::CFG_GRAVITY, phase_cfg[p][0]);
			cfg_write(tgs_pkg::CFG_ORIGIN_X, phase_cfg[p][1]);
			cfg_write(tgs_pkg::CFG_ORIGIN_Z, phase_cfg[p][2]);
			cfg_write(tgs_pkg::CFG_CELLS_PER_UNIT, phase_cfg[p][3]);
			cfg_we <= 1'b0;
			for (int k = 0; k < PHASE_LEN; k++) begin
				// alternate stretches with and without idling
				if (k % 70 == 0)
					quiet = ($urandom_range(0, 2) == 0);
				push_word(next_item(), 0, none, 0);
			end
			quiet = 0;
		end

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d height writes and %0d body steps over 7 config settings",
			n_writes, n_steps);
		$display("results seen: %0d landed, %0d off map, %0d clipped", n_landed, n_off, n_sat);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/tgs_pkg.sv
src/tgs_ram.sv
src/tgs_kin.sv
src/tgs_interp.sv
src/terrain_gravity_step.sv
verif/testbench.sv
